/* hw/rtl/cvg_pkg.sv */
// Shared types, constants and codes for the CV/gate to note event engine.
package cvg_pkg;

  // Sizes and limits
  localparam int VOICES_DEF  = 16;
  localparam int BLOCK_SIZE  = 128;
  localparam int OFFSET_MAX  = BLOCK_SIZE - 1;
  localparam int MAX_EVENTS  = 16;
  localparam int CNT_W       = $clog2(MAX_EVENTS);
  localparam int ID_W        = 31;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int RECIP_SHIFT = 19;

  localparam logic [ID_W-1:0]   ID_MAX      = '1;
  localparam logic [ID_W-1:0]   ID_FIRST    = 31'd1;
  localparam logic signed [15:0] GATE_ON    = 16'sd1024;
  localparam logic [10:0]       Q10_FULL    = 11'd1024;
  localparam logic [10:0]       DEFAULT_VEL = 11'd806;
  localparam logic [10:0]       THRESH_RST  = 11'd20;
  localparam logic [15:0]       RECIP_TEN   = 16'd52429;
  localparam logic [6:0]        NOTE_CENTRE = 7'd60;
  localparam logic [6:0]        NOTE_TOP    = 7'd127;

  // Register map, one word per register
  typedef enum logic [1:0] {
    REG_BYPASS     = 2'd0,
    REG_VEL_CONN   = 2'd1,
    REG_PRESS_CONN = 2'd2,
    REG_THRESH     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_VOICE = 1'b0,
    CMD_PANIC = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    EV_NOTE_ON    = 2'd0,
    EV_NOTE_OFF   = 2'd1,
    EV_POLY_PRESS = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OFF,
    ST_ON,
    ST_PRESS,
    ST_WALK,
    ST_PANIC_OFF
  } state_e;

  // Which event the output register is loaded with
  typedef enum logic [1:0] {
    SEL_OFF,
    SEL_ON,
    SEL_PRESS,
    SEL_PANIC
  } sel_e;

  typedef struct packed {
    logic              command;
    logic [3:0]        channel;
    logic [6:0]        sample_offset;
    logic signed [15:0] gate_voltage;
    logic signed [15:0] pitch_voltage;
    logic signed [15:0] velocity_voltage;
    logic signed [15:0] pressure_voltage;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]      event_kind;
    logic [6:0]      event_offset;
    logic [3:0]      event_channel;
    logic [6:0]      event_note;
    logic [ID_W-1:0] event_id;
    logic [10:0]     event_value;
    logic            last_event;
  } out_beat_t;

  typedef struct packed {
    logic        bypass;
    logic        velocity_connected;
    logic        pressure_connected;
    logic [10:0] pressure_threshold;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
    sel_e sel;
    logic walk_read;
    logic walk_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_panic;
    logic do_off;
    logic do_on;
    logic do_press;
    logic slot_free;
    logic walk_hit;
    logic walk_end;
    logic panic_last;
  } status_t;

endpackage

/* hw/rtl/cvg_regs.sv */
// APB-style configuration registers of the note event engine.
module cvg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cvg_pkg::CFG_AW-1:0] paddr,
  input  logic [cvg_pkg::CFG_DW-1:0] pwdata,
  output logic [cvg_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output cvg_pkg::cfg_t             cfg_o
);
  import cvg_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass             <= 1'b0;
      cfg_q.velocity_connected <= 1'b0;
      cfg_q.pressure_connected <= 1'b0;
      cfg_q.pressure_threshold <= THRESH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BYPASS:     cfg_q.bypass             <= pwdata[0];
        REG_VEL_CONN:   cfg_q.velocity_connected <= pwdata[0];
        REG_PRESS_CONN: cfg_q.pressure_connected <= pwdata[0];
        REG_THRESH:     cfg_q.pressure_threshold <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_BYPASS:     prdata = CFG_DW'(cfg_q.bypass);
      REG_VEL_CONN:   prdata = CFG_DW'(cfg_q.velocity_connected);
      REG_PRESS_CONN: prdata = CFG_DW'(cfg_q.pressure_connected);
      REG_THRESH:     prdata = CFG_DW'(cfg_q.pressure_threshold);
      default:        prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/cvg_ctrl.sv */
// Sequencing state machine: voice decisions, event emission and the panic walk.
module cvg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cvg_pkg::status_t  status_i,
  output cvg_pkg::cmd_t     cmd_o
);
  import cvg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.is_panic ? ST_WALK : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.do_off)        state_d = ST_OFF;
        else if (status_i.do_on)    state_d = ST_ON;
        else if (status_i.do_press) state_d = ST_PRESS;
        else                        state_d = ST_IDLE;
      end
      ST_OFF: begin
        if (status_i.slot_free) state_d = status_i.do_on ? ST_ON : ST_IDLE;
      end
      ST_ON: begin
        if (status_i.slot_free) state_d = status_i.do_press ? ST_PRESS : ST_IDLE;
      end
      ST_PRESS: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (status_i.walk_hit)      state_d = ST_PANIC_OFF;
        else if (status_i.walk_end) state_d = ST_IDLE;
      end
      ST_PANIC_OFF: begin
        if (status_i.slot_free) state_d = status_i.panic_last ? ST_IDLE : ST_WALK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_OFF;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_DECIDE: ;
      ST_OFF: begin
        cmd_o.emit = status_i.slot_free;
        cmd_o.sel  = SEL_OFF;
      end
      ST_ON: begin
        cmd_o.emit = status_i.slot_free;
        cmd_o.sel  = SEL_ON;
      end
      ST_PRESS: begin
        cmd_o.emit = status_i.slot_free;
        cmd_o.sel  = SEL_PRESS;
      end
      ST_WALK: begin
        cmd_o.walk_read = status_i.walk_hit;
        cmd_o.walk_step = !status_i.walk_hit && !status_i.walk_end;
      end
      ST_PANIC_OFF: begin
        cmd_o.emit      = status_i.slot_free;
        cmd_o.sel       = SEL_PANIC;
        cmd_o.walk_step = status_i.slot_free && !status_i.panic_last;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/cvg_datapath.sv */
// Voice state, note and Q10 arithmetic, panic walk and the output register.
module cvg_datapath #(
  parameter int VOICES = cvg_pkg::VOICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cvg_pkg::in_beat_t   in_data_i,
  input  cvg_pkg::cfg_t       cfg_i,
  input  cvg_pkg::cmd_t       cmd_i,
  output cvg_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cvg_pkg::out_beat_t  out_data_o
);
  import cvg_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Voice memories: written only while a voice is live, so no reset
  logic [6:0]      note_mem [VOICES];
  logic [ID_W-1:0] id_mem   [VOICES];
  logic [10:0]     pr_mem   [VOICES];

  // Per-voice flags
  logic [VOICES-1:0] active_q, pvalid_q, pending_q;

  // Captured beat and first-stage arithmetic
  in_beat_t          in_q;
  logic              was_q, pv_q, high_q;
  logic signed [19:0] t_q;
  logic [31:0]       vp_q, pp_q;
  logic [6:0]        rd_note_q;
  logic [ID_W-1:0]   rd_id_q;
  logic [10:0]       rd_pr_q;

  logic [ID_W-1:0] next_id_q, new_id_q;
  logic [VW-1:0]   idx_q;
  logic [CNT_W-1:0] cnt_q;

  logic      out_valid_q;
  out_beat_t out_q, out_d;

  // Combinational helpers
  logic              slot_free;
  logic [VW-1:0]     ch_idx, in_idx, rd_addr;
  logic              rd_en, ch_ok, in_ok, voice_ok;
  logic signed [19:0] pitch_ext;
  logic [15:0]       v_plus, p_plus;
  logic [31:0]       vp_d, pp_d;
  logic [19:0]       mag;
  logic [20:0]       rsum;
  logic [9:0]        rnd;
  logic [6:0]        note_c, off_c;
  logic [10:0]       vel_c, pr_c, pr_old, pr_diff;
  logic              chg, do_off, do_on, do_press, panic_last;
  logic [VOICES-1:0] others;

  function automatic logic [10:0] q10_of(input logic [31:0] prod);
    logic [12:0] q;
    q = prod[31:RECIP_SHIFT];
    return (q > 13'(Q10_FULL)) ? Q10_FULL : q[10:0];
  endfunction

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_idx    = VW'(in_data_i.channel);
  assign ch_idx    = VW'(in_q.channel);
  assign in_ok     = int'(in_data_i.channel) < VOICES;
  assign ch_ok     = int'(in_q.channel) < VOICES;
  assign voice_ok  = !cfg_i.bypass && ch_ok;

  // Input-side products: pitch times twelve, Q10 by reciprocal of ten
  assign pitch_ext = {{4{in_data_i.pitch_voltage[15]}}, in_data_i.pitch_voltage};
  assign v_plus    = $unsigned(in_data_i.velocity_voltage) + 16'd5;
  assign p_plus    = $unsigned(in_data_i.pressure_voltage) + 16'd5;
  assign vp_d = (in_data_i.velocity_voltage > 16'sd0) ?
                ({16'd0, v_plus} * {16'd0, RECIP_TEN}) : '0;
  assign pp_d = (in_data_i.pressure_voltage > 16'sd0) ?
                ({16'd0, p_plus} * {16'd0, RECIP_TEN}) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q   <= in_data_i;
      was_q  <= in_ok ? active_q[in_idx] : 1'b0;
      pv_q   <= in_ok ? pvalid_q[in_idx] : 1'b0;
      high_q <= in_data_i.gate_voltage > GATE_ON;
      t_q    <= pitch_ext * 20'sd12;
      vp_q   <= vp_d;
      pp_q   <= pp_d;
    end
  end

  // Note: round half away from zero, offset by the centre note, clamped
  always_comb begin
    mag  = t_q[19] ? 20'(-t_q) : 20'(t_q);
    rsum = 21'(mag) + 21'd512;
    rnd  = 10'(rsum >> 10);
    if (t_q[19]) begin
      note_c = (rnd > 10'(NOTE_CENTRE)) ? 7'd0 : 7'(10'(NOTE_CENTRE) - rnd);
    end else begin
      note_c = (rnd > 10'(NOTE_TOP - NOTE_CENTRE)) ? NOTE_TOP :
               7'(10'(NOTE_CENTRE) + rnd);
    end
  end

  // Event decisions, all from registers that hold still for the whole item
  always_comb begin
    off_c    = (int'(in_q.sample_offset) > OFFSET_MAX) ? 7'(OFFSET_MAX) :
               in_q.sample_offset;
    vel_c    = cfg_i.velocity_connected ? q10_of(vp_q) : DEFAULT_VEL;
    pr_c     = q10_of(pp_q);
    pr_old   = pv_q ? rd_pr_q : 11'd0;
    pr_diff  = (pr_c > pr_old) ? (pr_c - pr_old) : (pr_old - pr_c);
    chg      = note_c != rd_note_q;
    do_off   = voice_ok && was_q && (!high_q || chg);
    do_on    = voice_ok && high_q && (!was_q || chg);
    do_press = voice_ok && high_q && was_q && cfg_i.pressure_connected &&
               (pr_diff > cfg_i.pressure_threshold);
  end

  // Panic: last beat when the count limit is hit or nothing is left above
  always_comb begin
    others        = pending_q;
    others[idx_q] = 1'b0;
    panic_last    = (cnt_q == CNT_W'(MAX_EVENTS - 1)) || !(|others);
  end

  always_comb begin
    status_o.is_panic   = in_data_i.command == CMD_PANIC;
    status_o.do_off     = do_off;
    status_o.do_on      = do_on;
    status_o.do_press   = do_press;
    status_o.slot_free  = slot_free;
    status_o.walk_hit   = pending_q[idx_q];
    status_o.walk_end   = idx_q == VW'(VOICES - 1);
    status_o.panic_last = panic_last;
  end

  // Single read port: channel on accept, walk index during panic
  assign rd_en   = cmd_i.accept || cmd_i.walk_read;
  assign rd_addr = cmd_i.accept ? in_idx : idx_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_note_q <= note_mem[rd_addr];
      rd_id_q   <= id_mem[rd_addr];
      rd_pr_q   <= pr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.sel == SEL_ON) begin
      note_mem[ch_idx] <= note_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.sel == SEL_ON) begin
      id_mem[ch_idx] <= next_id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.sel == SEL_PRESS) begin
      pr_mem[ch_idx] <= pr_c;
    end
  end

  // Voice flags, id counter and walk position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      pvalid_q  <= '0;
      pending_q <= '0;
      next_id_q <= ID_FIRST;
      idx_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.accept && in_data_i.command == CMD_PANIC) begin
        pending_q <= active_q;
        active_q  <= '0;
        pvalid_q  <= '0;
        idx_q     <= '0;
        cnt_q     <= '0;
      end
      if (cmd_i.emit) begin
        case (cmd_i.sel)
          SEL_OFF: begin
            if (!high_q) active_q[ch_idx] <= 1'b0;
          end
          SEL_ON: begin
            active_q[ch_idx] <= 1'b1;
            next_id_q <= (next_id_q == ID_MAX) ? ID_FIRST : next_id_q + ID_FIRST;
          end
          SEL_PRESS: pvalid_q[ch_idx] <= 1'b1;
          SEL_PANIC: begin
            pending_q[idx_q] <= 1'b0;
            cnt_q <= cnt_q + CNT_W'(1);
          end
          default: ;
        endcase
      end
      if (cmd_i.walk_step) idx_q <= idx_q + VW'(1);
    end
  end

  // Id handed out by the latest note-on, for a pressure beat that follows it
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.sel == SEL_ON) new_id_q <= next_id_q;
  end

  // Output beat selection
  always_comb begin
    out_d.event_offset  = off_c;
    out_d.event_channel = in_q.channel;
    out_d.event_note    = rd_note_q;
    out_d.event_id      = rd_id_q;
    out_d.event_value   = 11'd0;
    out_d.event_kind    = EV_NOTE_OFF;
    out_d.last_event    = 1'b1;
    case (cmd_i.sel)
      SEL_OFF: out_d.last_event = !high_q;
      SEL_ON: begin
        out_d.event_kind  = EV_NOTE_ON;
        out_d.event_note  = note_c;
        out_d.event_id    = next_id_q;
        out_d.event_value = vel_c;
        out_d.last_event  = !do_press;
      end
      SEL_PRESS: begin
        out_d.event_kind  = EV_POLY_PRESS;
        out_d.event_note  = do_on ? note_c : rd_note_q;
        out_d.event_id    = do_on ? new_id_q : rd_id_q;
        out_d.event_value = pr_c;
      end
      SEL_PANIC: begin
        out_d.event_offset  = 7'd0;
        out_d.event_channel = 4'(idx_q);
        out_d.last_event    = panic_last;
      end
      default: ;
    endcase
  end

  // Output register: holds a beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("beat loaded while output register still full");

  a_panic_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && in_data_i.command == CMD_PANIC) |=>
      (active_q == '0 && pvalid_q == '0))
    else $error("panic left a voice active or a pressure stored");

  a_walk_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_read |-> pending_q[idx_q])
    else $error("panic read at a voice that was not pending");

  a_on_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_kind == EV_NOTE_ON) |-> out_q.event_id != '0)
    else $error("note-on carries a zero id");

  a_next_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("id counter reached zero");

endmodule

/* hw/rtl/poly_cv_gate_to_note_events.sv */
// Top level of the polyphonic CV/gate to note event engine.
// Voice beat: accept, a decision state, then one state per event (up to three: off, on,
//   pressure), each held while the output register is still full.
// Panic beat: accept, then a walk over the voices with a note-off for each active voice,
//   at most MAX_EVENTS. Output stalls hold both; an output register parts the sides.
// Reset clears all voices and stored pressures and restores configuration defaults; ids restart at one.
module poly_cv_gate_to_note_events #(
  parameter int VOICES = cvg_pkg::VOICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cvg_pkg::in_beat_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cvg_pkg::out_beat_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cvg_pkg::CFG_AW-1:0] paddr,
  input  logic [cvg_pkg::CFG_DW-1:0] pwdata,
  output logic [cvg_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import cvg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  cvg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cvg_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
